@@ design/idd_pkg.sv @@
// Shared types, constants and calendar tables for the inclusive date difference block.
`default_nettype none

package idd_pkg;

    localparam int DATE_W   = 27;
    localparam int YEAR_W   = 14;
    localparam int REM_W    = 14;
    localparam int MD_W     = 7;
    localparam int SERIAL_W = 23;
    localparam int COUNT_W  = 22;
    localparam int CUM_W    = 9;
    localparam int LEN_W    = 5;

    localparam logic [DATE_W-1:0] DATE_MAX = 27'd99991231;
    // Reciprocal of 625 scaled by 2**33; exact floor for any 23-bit dividend.
    localparam logic [23:0] YEAR_MAGIC = 24'd13743896;
    // Reciprocal of 100 scaled by 2**19; exact floor below 43699.
    localparam logic [12:0] DIV100_MAGIC = 13'd5243;

    typedef struct packed {
        logic                ok;
        logic [SERIAL_W-1:0] serial;
    } t_lane_res;

    typedef struct packed {
        logic               invalid;
        logic [COUNT_W-1:0] day_count;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LANES,
        ST_MERGE,
        ST_HOLD
    } t_state;

    function automatic logic [LEN_W-1:0] month_len(input logic [MD_W-1:0] m,
                                                    input logic leap);
        logic [LEN_W-1:0] len;
        unique case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
            7'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [CUM_W-1:0] month_cum(input logic [MD_W-1:0] m,
                                                    input logic leap);
        logic [CUM_W-1:0] cum;
        unique case (m)
            7'd1:    cum = 9'd0;
            7'd2:    cum = 9'd31;
            7'd3:    cum = 9'd59;
            7'd4:    cum = 9'd90;
            7'd5:    cum = 9'd120;
            7'd6:    cum = 9'd151;
            7'd7:    cum = 9'd181;
            7'd8:    cum = 9'd212;
            7'd9:    cum = 9'd243;
            7'd10:   cum = 9'd273;
            7'd11:   cum = 9'd304;
            7'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        // February 29 falls before every month after February in a leap year.
        if (leap && (m > 7'd2) && (m < 7'd13)) begin
            cum = cum + 9'd1;
        end
        return cum;
    endfunction

endpackage

`default_nettype wire

@@ design/inclusive_date_difference.sv @@
// Top level: inclusive Gregorian day count between two packed YYYYMMDD dates.
//
// Channel   Dir  Signals                           Word contents (lowest bit up)
// s_axis    in   tvalid, tready, tdata[55:0]       first_date[26:0], second_date[26:0]
// m_axis    out  tvalid, tready, tdata[23:0], tuser day_count[21:0]; tuser: date_invalid
//
// One word is in flight at a time: an accepted word reaches the output register through
// the six lane stages (the first loads on the accepting edge), the merge register, one state
// step from merge to hold, and the output load.
// The input takes a new word in the cycle after that load; a waiting output word holds the
// next result and keeps the input closed.
// Reset is synchronous and active low; it clears the control state and the output valid.
`default_nettype none

module inclusive_date_difference
    import idd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // first_date[26:0], second_date[53:27], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // day_count[21:0], zero pad
    output logic [0:0]       m_axis_tuser    // date_invalid
);

    t_state    r_state;
    t_state    n_state;
    logic      w_accept;
    logic      w_load;
    logic      w_done_a;
    logic      w_done_b;
    logic      w_lanes_done;
    logic      w_merge_valid;
    logic      r_swap;
    t_lane_res w_res_a;
    t_lane_res w_res_b;
    t_result   w_merge_res;
    logic      r_out_vld;
    t_result   r_out;

    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_lanes_done = w_done_a && w_done_b;

    idd_lane u_lane_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_date  (s_axis_tdata[26:0]),
        .o_done  (w_done_a),
        .o_res   (w_res_a)
    );

    idd_lane u_lane_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_date  (s_axis_tdata[53:27]),
        .o_done  (w_done_b),
        .o_res   (w_res_b)
    );

    // The earlier date is the smaller packed value.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_swap <= (s_axis_tdata[26:0] > s_axis_tdata[53:27]);
        end
    end

    idd_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_lanes_done),
        .i_swap   (r_swap),
        .i_res_a  (w_res_a),
        .i_res_b  (w_res_b),
        .o_valid  (w_merge_valid),
        .o_result (w_merge_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_load        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_LANES;
                end
            end
            ST_LANES: begin
                if (w_lanes_done) begin
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (w_merge_valid) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!r_out_vld || m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_merge_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out.day_count};
    assign m_axis_tuser  = r_out.invalid;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[21:0] == 22'd0))
        else $error("invalid result carries a nonzero day count");

    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[21:0] != 22'd0))
        else $error("valid result carries a zero day count");

    a_lanes_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lanes_done |-> (r_state == ST_LANES))
        else $error("lanes finished outside the lane wait state");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_LANES))
        else $error("accepted word did not start the lanes");

endmodule

`default_nettype wire

@@ design/idd_lane.sv @@
// One lane: splits a packed date and turns it into a checked serial day number.
`default_nettype none

module idd_lane
    import idd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DATE_W-1:0] i_date,
    output logic                   o_done,
    output t_lane_res              o_res
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] r_vld;

    // Stage 1: range check and year by reciprocal multiply.
    logic [46:0]       w_prod_y;
    logic [DATE_W-1:0] r1_date;
    logic [YEAR_W-1:0] r1_y;
    logic              r1_rng;

    // Stage 2: remainder MMDD and century number.
    logic [DATE_W-1:0] w_y_times;
    logic [26:0]       w_prod_c;
    logic [REM_W-1:0]  r2_rem;
    logic [YEAR_W-1:0] r2_y;
    logic [7:0]        r2_c;
    logic              r2_rng;

    // Stage 3: month and leap flag.
    logic [26:0]       w_prod_m;
    logic              w_cen;
    logic [MD_W-1:0]   r3_m;
    logic [REM_W-1:0]  r3_rem;
    logic [YEAR_W-1:0] r3_y;
    logic              r3_leap;
    logic              r3_rng;

    // Stage 4: day and the century corrections.
    logic [REM_W-1:0]  w_m_times;
    logic [REM_W-1:0]  w_d_full;
    logic [26:0]       w_prod_q100;
    logic [26:0]       w_prod_q400;
    logic [YEAR_W:0]   w_y99;
    logic [YEAR_W:0]   w_y399;
    logic [MD_W-1:0]   r4_d;
    logic [MD_W-1:0]   r4_m;
    logic [YEAR_W-1:0] r4_y;
    logic [7:0]        r4_q100;
    logic [7:0]        r4_q400;
    logic              r4_leap;
    logic              r4_rng;

    // Stage 5: days before the year, days before the month, validity.
    logic [LEN_W-1:0]    w_len;
    logic [SERIAL_W-1:0] r5_ys;
    logic [CUM_W-1:0]    r5_cum;
    logic [MD_W-1:0]     r5_d;
    logic                r5_ok;

    // Stage 6: final sum.
    t_lane_res r6_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_start};
        end
    end

    assign w_prod_y = 47'(i_date[DATE_W-1:4]) * 47'(YEAR_MAGIC);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r1_date <= i_date;
            r1_y    <= w_prod_y[46:33];
            r1_rng  <= (i_date <= DATE_MAX);
        end
    end

    assign w_y_times = 27'(r1_y) * 27'd10000;
    assign w_prod_c  = 27'(r1_y) * 27'(DIV100_MAGIC);

    always_ff @(posedge i_clk) begin
        if (r_vld[0]) begin
            r2_rem <= REM_W'(r1_date - w_y_times);
            r2_y   <= r1_y;
            r2_c   <= w_prod_c[26:19];
            r2_rng <= r1_rng;
        end
    end

    assign w_prod_m = 27'(r2_rem) * 27'(DIV100_MAGIC);
    assign w_cen    = (r2_y == YEAR_W'(15'(r2_c) * 15'd100));

    always_ff @(posedge i_clk) begin
        if (r_vld[1]) begin
            r3_m    <= w_prod_m[25:19];
            r3_rem  <= r2_rem;
            r3_y    <= r2_y;
            r3_leap <= ((r2_y[1:0] == 2'd0) && !w_cen) || (w_cen && (r2_c[1:0] == 2'd0));
            r3_rng  <= r2_rng;
        end
    end

    assign w_m_times   = REM_W'(r3_m) * REM_W'(100);
    assign w_d_full    = r3_rem - w_m_times;
    assign w_y99       = (YEAR_W+1)'(r3_y) + (YEAR_W+1)'(99);
    assign w_y399      = (YEAR_W+1)'(r3_y) + (YEAR_W+1)'(399);
    assign w_prod_q100 = 27'(w_y99) * 27'(DIV100_MAGIC);
    assign w_prod_q400 = 27'(w_y399[YEAR_W:2]) * 27'(DIV100_MAGIC);

    always_ff @(posedge i_clk) begin
        if (r_vld[2]) begin
            r4_d    <= w_d_full[MD_W-1:0];
            r4_m    <= r3_m;
            r4_y    <= r3_y;
            r4_q100 <= w_prod_q100[26:19];
            r4_q400 <= w_prod_q400[26:19];
            r4_leap <= r3_leap;
            r4_rng  <= r3_rng;
        end
    end

    assign w_len = month_len(r4_m, r4_leap);

    always_ff @(posedge i_clk) begin
        if (r_vld[3]) begin
            r5_ys  <= SERIAL_W'(r4_y) * SERIAL_W'(365)
                      + SERIAL_W'((YEAR_W+1)'(r4_y) + (YEAR_W+1)'(3) >> 2)
                      - SERIAL_W'(r4_q100) + SERIAL_W'(r4_q400);
            r5_cum <= month_cum(r4_m, r4_leap);
            r5_d   <= r4_d;
            // A month outside 1..12 gives a length of zero, so the day test fails too.
            r5_ok  <= r4_rng && (r4_d != '0) && (r4_d <= MD_W'(w_len));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[4]) begin
            r6_res.ok     <= r5_ok;
            r6_res.serial <= r5_ys + SERIAL_W'(r5_cum) + SERIAL_W'(r5_d) - SERIAL_W'(1);
        end
    end

    assign o_done = r_vld[STAGES-1];
    assign o_res  = r6_res;

endmodule

`default_nettype wire

@@ design/idd_merge.sv @@
// Merging stage: orders the two lane results and forms the inclusive day count.
`default_nettype none

module idd_merge
    import idd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire logic      i_swap,
    input  wire t_lane_res i_res_a,
    input  wire t_lane_res i_res_b,
    output logic           o_valid,
    output t_result        o_result
);

    logic [SERIAL_W-1:0] w_lo;
    logic [SERIAL_W-1:0] w_hi;
    logic [SERIAL_W-1:0] w_span;
    logic                w_ok;
    logic                r_valid;
    t_result             r_result;

    assign w_lo   = i_swap ? i_res_b.serial : i_res_a.serial;
    assign w_hi   = i_swap ? i_res_a.serial : i_res_b.serial;
    assign w_span = w_hi - w_lo + SERIAL_W'(1);
    assign w_ok   = i_res_a.ok && i_res_b.ok && (w_hi >= w_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_result.invalid   <= !w_ok;
            r_result.day_count <= w_ok ? w_span[COUNT_W-1:0] : '0;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire
